### hdl/lcdns_pkg.sv
// ----------------------------------------------------------------------------
// lcdns_pkg
// Types, codes and microcode layout for the character LCD nibble sequencer.
// ----------------------------------------------------------------------------
package lcdns_pkg;

	localparam int StepW = 5;

	typedef logic [StepW-1:0] step_t;

	// request codes
	localparam logic [2:0] FN_INIT   = 3'd0;
	localparam logic [2:0] FN_DATA   = 3'd1;
	localparam logic [2:0] FN_CURSOR = 3'd2;
	localparam logic [2:0] FN_CLEAR  = 3'd3;
	localparam logic [2:0] FN_OFF    = 3'd4;
	localparam logic [2:0] FN_STEADY = 3'd5;
	localparam logic [2:0] FN_BLINK  = 3'd6;
	localparam logic [2:0] FN_NONE   = 3'd7;

	// configuration register indexes
	localparam logic [1:0] REG_PULSE = 2'd0;
	localparam logic [1:0] REG_SHORT = 2'd1;
	localparam logic [1:0] REG_CLEAR = 2'd2;

	// fixed waits in us
	localparam logic [15:0] IDLE_US     = 16'd31000;
	localparam logic [15:0] FS1_WAIT_US = 16'd4500;
	localparam logic [15:0] FS2_WAIT_US = 16'd150;

	// program entry points
	localparam step_t EP_INIT   = 5'd0;
	localparam step_t EP_DATA   = 5'd10;
	localparam step_t EP_CURSOR = 5'd11;
	localparam step_t EP_CLEAR  = 5'd12;
	localparam step_t EP_OFF    = 5'd14;
	localparam step_t EP_STEADY = 5'd15;
	localparam step_t EP_BLINK  = 5'd16;

	typedef enum logic [1:0] {
		SRC_CONST = 2'd0,
		SRC_DATA  = 2'd1,
		SRC_ADDR  = 2'd2
	} src_t;

	typedef enum logic [2:0] {
		WT_SHORT = 3'd0,
		WT_CLEAR = 3'd1,
		WT_FS1   = 3'd2,
		WT_FS2   = 3'd3,
		WT_NONE  = 3'd4
	} wsel_t;

	// one control word per program step
	typedef struct packed {
		src_t        src;
		logic [7:0]  konst;
		logic        rs;
		wsel_t       wsel;
		logic        idle;   // single all-low power-up segment
		logic        fin;    // last step of the request
	} ucode_t;

	typedef struct packed {
		step_t entry;
		logic  ok;
	} dispatch_t;

endpackage

### hdl/lcdns_urom.sv
// ----------------------------------------------------------------------------
// lcdns_urom
// Microcode ROM and request dispatch table.
// ----------------------------------------------------------------------------
module lcdns_urom
	import lcdns_pkg::*;
(
	input  step_t      step,
	input  logic [2:0] func,
	output ucode_t     uc,
	output dispatch_t  disp
);

	function automatic ucode_t mk(src_t s, logic [7:0] k, logic r, wsel_t w,
	                              logic i, logic f);
		ucode_t u;
		u.src   = s;
		u.konst = k;
		u.rs    = r;
		u.wsel  = w;
		u.idle  = i;
		u.fin   = f;
		return u;
	endfunction

	always_comb begin
		case (step)
			5'd0:    uc = mk(SRC_CONST, 8'h00, 1'b0, WT_NONE,  1'b1, 1'b0);
			5'd1:    uc = mk(SRC_CONST, 8'h30, 1'b0, WT_FS1,   1'b0, 1'b0);
			5'd2:    uc = mk(SRC_CONST, 8'h30, 1'b0, WT_FS2,   1'b0, 1'b0);
			5'd3:    uc = mk(SRC_CONST, 8'h30, 1'b0, WT_SHORT, 1'b0, 1'b0);
			5'd4:    uc = mk(SRC_CONST, 8'h20, 1'b0, WT_SHORT, 1'b0, 1'b0);
			5'd5:    uc = mk(SRC_CONST, 8'h20, 1'b0, WT_SHORT, 1'b0, 1'b0);
			5'd6:    uc = mk(SRC_CONST, 8'h28, 1'b0, WT_SHORT, 1'b0, 1'b0);
			5'd7:    uc = mk(SRC_CONST, 8'h0F, 1'b0, WT_SHORT, 1'b0, 1'b0);
			5'd8:    uc = mk(SRC_CONST, 8'h01, 1'b0, WT_CLEAR, 1'b0, 1'b0);
			5'd9:    uc = mk(SRC_CONST, 8'h06, 1'b0, WT_SHORT, 1'b0, 1'b1);
			5'd10:   uc = mk(SRC_DATA,  8'h00, 1'b1, WT_SHORT, 1'b0, 1'b1);
			5'd11:   uc = mk(SRC_ADDR,  8'h00, 1'b0, WT_SHORT, 1'b0, 1'b1);
			5'd12:   uc = mk(SRC_CONST, 8'h01, 1'b0, WT_CLEAR, 1'b0, 1'b0);
			5'd13:   uc = mk(SRC_CONST, 8'h02, 1'b0, WT_CLEAR, 1'b0, 1'b1);
			5'd14:   uc = mk(SRC_CONST, 8'h0C, 1'b0, WT_SHORT, 1'b0, 1'b1);
			5'd15:   uc = mk(SRC_CONST, 8'h0E, 1'b0, WT_SHORT, 1'b0, 1'b1);
			5'd16:   uc = mk(SRC_CONST, 8'h0F, 1'b0, WT_SHORT, 1'b0, 1'b1);
			default: uc = mk(SRC_CONST, 8'h00, 1'b0, WT_SHORT, 1'b0, 1'b1);
		endcase
	end

	always_comb begin
		disp.ok = 1'b1;
		case (func)
			FN_INIT:   disp.entry = EP_INIT;
			FN_DATA:   disp.entry = EP_DATA;
			FN_CURSOR: disp.entry = EP_CURSOR;
			FN_CLEAR:  disp.entry = EP_CLEAR;
			FN_OFF:    disp.entry = EP_OFF;
			FN_STEADY: disp.entry = EP_STEADY;
			FN_BLINK:  disp.entry = EP_BLINK;
			default: begin
				disp.entry = EP_INIT;
				disp.ok    = 1'b0;
			end
		endcase
	end

endmodule

### hdl/lcdns_seq.sv
// ----------------------------------------------------------------------------
// lcdns_seq
// Step counter, nibble phase counter and segment datapath with output register.
// ----------------------------------------------------------------------------
module lcdns_seq
	import lcdns_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  step_t       entry,
	input  ucode_t      uc,
	output step_t       step,
	output logic        busy,
	input  logic [7:0]  data_byte,
	input  logic [7:0]  addr_byte,
	input  logic [7:0]  pulse_us,
	input  logic [11:0] short_wait_us,
	input  logic [14:0] clear_wait_us,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        out_rs,
	output logic        out_en,
	output logic [3:0]  out_nibble,
	output logic [15:0] out_hold,
	output logic        out_last
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t      state_q;
	step_t       step_q;
	logic [2:0]  phase_q;
	logic        valid_q;
	logic        rs_q;
	logic        en_q;
	logic [3:0]  nib_q;
	logic [15:0] hold_q;
	logic        last_q;

	logic        adv;
	logic [7:0]  byte_val;
	logic [15:0] wait_val;
	logic [16:0] sum;
	logic        byte_end;
	logic        seg_en;
	logic [3:0]  seg_nib;
	logic [15:0] seg_hold;

	assign adv = (state_q == ST_RUN) && (!valid_q || out_ready);

	always_comb begin
		case (uc.src)
			SRC_DATA: byte_val = data_byte;
			SRC_ADDR: byte_val = addr_byte;
			default:  byte_val = uc.konst;
		endcase
	end

	always_comb begin
		case (uc.wsel)
			WT_SHORT: wait_val = {4'd0, short_wait_us};
			WT_CLEAR: wait_val = {1'b0, clear_wait_us};
			WT_FS1:   wait_val = FS1_WAIT_US;
			WT_FS2:   wait_val = FS2_WAIT_US;
			default:  wait_val = 16'd0;
		endcase
	end

	assign sum      = {9'd0, pulse_us} + {1'b0, wait_val};
	assign byte_end = uc.idle || (phase_q == 3'd5);

	always_comb begin
		seg_nib  = (phase_q < 3'd3) ? byte_val[7:4] : byte_val[3:0];
		seg_en   = (phase_q == 3'd1) || (phase_q == 3'd4);
		seg_hold = {8'd0, pulse_us};
		if (phase_q == 3'd5)
			seg_hold = sum[16] ? 16'hFFFF : sum[15:0];
		if (uc.idle) begin
			seg_nib  = 4'd0;
			seg_en   = 1'b0;
			seg_hold = IDLE_US;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= EP_INIT;
			phase_q <= 3'd0;
			valid_q <= 1'b0;
		end else begin
			if (adv)
				valid_q <= 1'b1;
			else if (out_ready)
				valid_q <= 1'b0;
			if (start) begin
				state_q <= ST_RUN;
				step_q  <= entry;
				phase_q <= 3'd0;
			end else if (adv) begin
				if (byte_end) begin
					phase_q <= 3'd0;
					if (uc.fin)
						state_q <= ST_IDLE;
					else
						step_q <= step_q + 1'b1;
				end else begin
					phase_q <= phase_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rs_q   <= uc.rs & ~uc.idle;
			en_q   <= seg_en;
			nib_q  <= seg_nib;
			hold_q <= seg_hold;
			last_q <= byte_end & uc.fin;
		end
	end

	assign step       = step_q;
	assign busy       = (state_q == ST_RUN);
	assign out_valid  = valid_q;
	assign out_rs     = rs_q;
	assign out_en     = en_q;
	assign out_nibble = nib_q;
	assign out_hold   = hold_q;
	assign out_last   = last_q;

endmodule

### hdl/char_lcd_nibble_sequencer.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer
// Turns LCD requests into timed pin segments for a 4-bit character LCD bus.
// ----------------------------------------------------------------------------
// A request is taken when the sequencer is free; it then issues one pin
// segment per cycle while the output side accepts them: 55 segments for
// initialize, 12 for clear, 6 for every other request, none for code 7.
// The rate is set by the microcode step counter, which walks one program step
// per byte and one nibble phase per cycle; the next request is taken in the
// cycle after the last segment enters the output register. Each segment
// gives rs, en, the D7..D4 nibble and the time in microseconds to hold them.
module char_lcd_nibble_sequencer
	import lcdns_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // func[2:0], data_byte[10:3], row[11], column[17:12]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // en[0], nibble[4:1], hold_us[20:5]
	output logic        m_tuser,   // rs
	output logic        m_tlast,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [14:0] wr_data
);

	logic [7:0]  pulse_q;
	logic [11:0] short_q;
	logic [14:0] clear_q;
	logic [7:0]  data_q;
	logic [7:0]  addr_q;

	logic        s_acc;
	logic        busy;
	step_t       step;
	ucode_t      uc;
	dispatch_t   disp;
	logic        en;
	logic [3:0]  nibble;
	logic [15:0] hold_us;

	assign s_acc    = s_tvalid && s_tready;
	assign s_tready = !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_q <= 8'd2;
			short_q <= 12'd50;
			clear_q <= 15'd2000;
		end else if (wr_en) begin
			case (wr_index)
				REG_PULSE: pulse_q <= wr_data[7:0];
				REG_SHORT: short_q <= wr_data[11:0];
				REG_CLEAR: clear_q <= wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			data_q <= s_tdata[10:3];
			addr_q <= {1'b1, s_tdata[11], s_tdata[17:12]};
		end
	end

	lcdns_urom u_urom (
		.step (step),
		.func (s_tdata[2:0]),
		.uc   (uc),
		.disp (disp)
	);

	lcdns_seq u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (s_acc && disp.ok),
		.entry         (disp.entry),
		.uc            (uc),
		.step          (step),
		.busy          (busy),
		.data_byte     (data_q),
		.addr_byte     (addr_q),
		.pulse_us      (pulse_q),
		.short_wait_us (short_q),
		.clear_wait_us (clear_q),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.out_rs        (m_tuser),
		.out_en        (en),
		.out_nibble    (nibble),
		.out_hold      (hold_us),
		.out_last      (m_tlast)
	);

	assign m_tdata = {3'd0, hold_us, nibble, en};

	// a real request locks out the input side
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && s_tdata[2:0] != FN_NONE) |=> !s_tready)
		else $error("request accepted but sequencer not busy");

	// unused code emits nothing
	a_none_free: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && s_tdata[2:0] == FN_NONE) |=> s_tready)
		else $error("unused request code started the sequencer");

	// a request always ends with the strobe low
	a_last_en_low: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> !m_tdata[0])
		else $error("final segment with enable high");

endmodule
